// ===== hdl/tlvpp_pkg.sv =====
package tlvpp_pkg;

    localparam int unsigned BODY_KEEP = 13;
    localparam int unsigned BODY_IDX_W = $clog2(BODY_KEEP);
    localparam logic [8:0] PACKET_BYTES = 9'd64;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 1'd1;

    localparam logic [15:0] PERIOD_RESET = 16'd100;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [7:0] TY_STATUS = 8'h40;
    localparam logic [7:0] TY_POSITION = 8'h41;
    localparam logic [7:0] TY_DISTANCE = 8'h48;
    localparam logic [7:0] TY_ANCHOR = 8'h49;

    localparam logic [3:0] EV_NONE = 4'd0;
    localparam logic [3:0] EV_POS = 4'd1;
    localparam logic [3:0] EV_OK = 4'd2;
    localparam logic [3:0] EV_ERR = 4'd3;
    localparam logic [3:0] EV_CLOSED = 4'd4;
    localparam logic [3:0] EV_BIG = 4'd5;
    localparam logic [3:0] EV_UNHANDLED = 4'd6;
    localparam logic [3:0] EV_TIMEOUT = 4'd7;
    localparam logic [3:0] EV_SENT = 4'd8;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [15:0]            data;
    } cfg_wr_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } step_in_t;

    typedef struct packed {
        logic [3:0]         event_res;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         quality;
        logic               awaiting_reply;
    } step_res_t;

endpackage

// ===== hdl/tlvpp_if.sv =====
interface tlvpp_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface tlvpp_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         event_res;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         quality;
    logic               awaiting_reply;

    modport source (output valid, output event_res, output pos_x, output pos_y,
                    output pos_z, output quality, output awaiting_reply, input ready);
    modport sink (input valid, input event_res, input pos_x, input pos_y,
                  input pos_z, input quality, input awaiting_reply, output ready);
endinterface

interface tlvpp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tlvpp_pkg::CFG_INDEX_W-1:0]   index;
    logic [15:0]                         data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tlvpp_engine.sv =====
module tlvpp_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlvpp_pkg::cfg_wr_t    cfg_wr,
    input  logic                  step,
    input  tlvpp_pkg::step_in_t   step_in,
    output tlvpp_pkg::step_res_t  step_res
);

    logic [15:0] period_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic        open_reg, open_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  body_reg [tlvpp_pkg::BODY_KEEP];
    logic [7:0]  body_next [tlvpp_pkg::BODY_KEEP];

    logic [15:0] elapsed_inc;
    logic [8:0]  body_idx;
    logic [8:0]  total;
    logic [8:0]  rec_len;
    logic        done;
    logic [3:0]  ev;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        open_next    = open_reg;
        elapsed_next = elapsed_reg;
        body_next    = body_reg;
        ev           = tlvpp_pkg::EV_NONE;
        done         = 1'b0;
        total        = {1'b0, step_in.rx_byte} + 9'd2;
        body_idx     = pos_reg - 9'd2;
        elapsed_inc  = (elapsed_reg != 16'hFFFF) ? elapsed_reg + 16'd1 : elapsed_reg;
        step_res     = '0;

        if (step_in.func)
        begin
            elapsed_next = elapsed_inc;
            if (!open_reg)
            begin
                if (period_reg == 16'd0 || elapsed_inc >= period_reg)
                begin
                    elapsed_next = 16'd0;
                    open_next    = 1'b1;
                    phase_next   = tlvpp_pkg::PH_TYPE;
                    pos_next     = 9'd0;
                    len_next     = 9'd0;
                    ev           = tlvpp_pkg::EV_SENT;
                end
            end
            else if (elapsed_inc > timeout_reg)
            begin
                open_next  = 1'b0;
                phase_next = tlvpp_pkg::PH_TYPE;
                pos_next   = 9'd0;
                len_next   = 9'd0;
                ev         = tlvpp_pkg::EV_TIMEOUT;
            end
        end
        else
        begin
            case (phase_reg)
                tlvpp_pkg::PH_TYPE:
                begin
                    type_next  = step_in.rx_byte;
                    pos_next   = 9'd1;
                    phase_next = tlvpp_pkg::PH_LEN;
                end
                tlvpp_pkg::PH_LEN:
                begin
                    if (total > tlvpp_pkg::PACKET_BYTES)
                    begin
                        open_next  = 1'b0;
                        phase_next = tlvpp_pkg::PH_TYPE;
                        pos_next   = 9'd0;
                        len_next   = 9'd0;
                        ev         = tlvpp_pkg::EV_BIG;
                    end
                    else
                    begin
                        len_next   = total;
                        pos_next   = 9'd2;
                        phase_next = tlvpp_pkg::PH_BODY;
                        done       = (total == 9'd2);
                    end
                end
                default:
                begin
                    if (pos_reg >= 9'd2 && body_idx < 9'(tlvpp_pkg::BODY_KEEP))
                        body_next[body_idx[tlvpp_pkg::BODY_IDX_W-1:0]] = step_in.rx_byte;
                    pos_next = pos_reg + 9'd1;
                    done     = (pos_next >= len_reg);
                end
            endcase
        end

        // complete record: act on type and kept body bytes
        if (done)
        begin
            rec_len    = len_next - 9'd2;
            phase_next = tlvpp_pkg::PH_TYPE;
            pos_next   = 9'd0;
            len_next   = 9'd0;
            if (type_next == tlvpp_pkg::TY_STATUS && rec_len >= 9'd1)
            begin
                if (body_next[0] != 8'd0)
                begin
                    open_next = 1'b0;
                    ev        = tlvpp_pkg::EV_ERR;
                end
                else
                    ev = tlvpp_pkg::EV_OK;
            end
            else if (type_next == tlvpp_pkg::TY_POSITION && rec_len >= 9'd13)
            begin
                ev               = tlvpp_pkg::EV_POS;
                step_res.pos_x   = {body_next[1], body_next[0]};
                step_res.pos_y   = {body_next[5], body_next[4]};
                step_res.pos_z   = {body_next[9], body_next[8]};
                step_res.quality = body_next[12];
            end
            else if ((type_next == tlvpp_pkg::TY_DISTANCE ||
                      type_next == tlvpp_pkg::TY_ANCHOR) && rec_len >= 9'd1)
            begin
                open_next = 1'b0;
                ev        = tlvpp_pkg::EV_CLOSED;
            end
            else
                ev = tlvpp_pkg::EV_UNHANDLED;
        end
        else
            rec_len = 9'd0;

        step_res.event_res      = ev;
        step_res.awaiting_reply = open_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= tlvpp_pkg::PERIOD_RESET;
            timeout_reg <= tlvpp_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr.we)
        begin
            case (cfg_wr.index)
                tlvpp_pkg::REG_REQUEST_PERIOD: period_reg <= cfg_wr.data;
                tlvpp_pkg::REG_TIMEOUT:        timeout_reg <= cfg_wr.data;
                default:                       period_reg <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tlvpp_pkg::PH_TYPE;
            pos_reg     <= 9'd0;
            len_reg     <= 9'd0;
            type_reg    <= 8'd0;
            open_reg    <= 1'b0;
            elapsed_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            open_reg    <= open_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // body bytes are only read after the current record wrote them
    always_ff @(posedge clk)
    begin
        if (step)
            body_reg <= body_next;
    end

endmodule

// ===== hdl/tlv_position_poller_core.sv =====
// Position poller with a type/length/value reply parser.
// Channels: rx takes one word per step, either a received byte (func = 0)
// or a one millisecond tick (func = 1). res returns exactly one word per
// rx word, in order: the event code, position fields on a position record
// (zero otherwise) and whether a request is open after the step. cfg
// writes request_period_ms (index 0) and timeout_ms (index 1); it is
// always ready, and the user must write it only while no word is in
// flight, as the block does not enforce this. Order: a word accepted
// is held in the input register, processed and loaded into the result
// register, which raises res.valid; a stalled result register holds it off.
// Throughput: one word per cycle while the result register is not stalled,
// set by the single pass from the input register through the parser and poll logic into the result register.
// Stall: while res.ready is low the result register holds its word; the
// input register still takes one more word, then rx.ready drops.
// Reset: both registers empty, parser waits for a type byte, no request
// open, elapsed counter zero, period 100 ms, timeout 200 ms.
module tlv_position_poller_core (
    input logic              clk,
    input logic              rst_n,
    tlvpp_in_if.sink         rx,
    tlvpp_out_if.source      res,
    tlvpp_cfg_if.sink        cfg
);

    logic                  in_valid_reg;
    tlvpp_pkg::step_in_t   in_word_reg;
    logic                  out_valid_reg;
    tlvpp_pkg::step_res_t  out_word_reg;
    tlvpp_pkg::step_res_t  step_res;
    tlvpp_pkg::cfg_wr_t    cfg_wr;
    logic                  advance;
    logic                  step;

    assign advance  = !out_valid_reg || res.ready;
    assign step     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.we    = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    tlvpp_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .step     (step),
        .step_in  (in_word_reg),
        .step_res (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_word_reg.func    <= rx.func;
            in_word_reg.rx_byte <= rx.rx_byte;
        end
        if (step)
            out_word_reg <= step_res;
    end

    assign res.valid          = out_valid_reg;
    assign res.event_res      = out_word_reg.event_res;
    assign res.pos_x          = out_word_reg.pos_x;
    assign res.pos_y          = out_word_reg.pos_y;
    assign res.pos_z          = out_word_reg.pos_z;
    assign res.quality        = out_word_reg.quality;
    assign res.awaiting_reply = out_word_reg.awaiting_reply;

endmodule

// ===== tb/tlv_position_poller_core_tb.sv =====
module tlv_position_poller_core_tb;
    import tlvpp_pkg::*;

    logic clk;
    logic rst_n;

    tlvpp_in_if  rx_if ();
    tlvpp_out_if res_if ();
    tlvpp_cfg_if cfg_if ();

    tlv_position_poller_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // poller state as the block should hold it
    logic [1:0]  pl_phase;
    logic [8:0]  pl_byte_pos;
    logic [8:0]  pl_rec_len;
    logic [7:0]  pl_rec_type;
    logic [7:0]  pl_body [BODY_KEEP];
    logic        pl_req_open;
    logic [15:0] pl_elapsed;
    logic [15:0] pl_period;
    logic [15:0] pl_timeout;

    step_res_t   pending_events [$];
    logic [7:0]  frame_body [$];

    logic        in_idle_on;
    logic        out_idle_on;
    int          words_sent;
    int          mismatch_count;
    int          stray_count;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic void parser_restart();
        pl_phase    = PH_TYPE;
        pl_byte_pos = 9'd0;
        pl_rec_len  = 9'd0;
    endfunction

    function automatic void poller_reset();
        int i;
        parser_restart();
        pl_rec_type = 8'd0;
        for (i = 0; i < int'(BODY_KEEP); i++)
            pl_body[i] = 8'd0;
        pl_req_open = 1'b0;
        pl_elapsed  = 16'd0;
        pl_period   = PERIOD_RESET;
        pl_timeout  = TIMEOUT_RESET;
    endfunction

    function automatic void close_record(inout step_res_t r);
        logic [8:0] blen;
        logic [7:0] ty;
        blen = pl_rec_len - 9'd2;
        ty   = pl_rec_type;
        parser_restart();
        if (ty == TY_STATUS && blen >= 9'd1)
        begin
            if (pl_body[0] != 8'd0)
            begin
                pl_req_open = 1'b0;
                r.event_res = EV_ERR;
            end
            else
                r.event_res = EV_OK;
        end
        else if (ty == TY_POSITION && blen >= 9'(BODY_KEEP))
        begin
            r.pos_x     = {pl_body[1], pl_body[0]};
            r.pos_y     = {pl_body[5], pl_body[4]};
            r.pos_z     = {pl_body[9], pl_body[8]};
            r.quality   = pl_body[12];
            r.event_res = EV_POS;
        end
        else if ((ty == TY_DISTANCE || ty == TY_ANCHOR) && blen >= 9'd1)
        begin
            pl_req_open = 1'b0;
            r.event_res = EV_CLOSED;
        end
        else
            r.event_res = EV_UNHANDLED;
    endfunction

    function automatic step_res_t poll_parse_step(input logic f, input logic [7:0] b);
        step_res_t  r;
        logic [8:0] total;
        logic [8:0] body_at;
        r = '0;
        r.event_res = EV_NONE;
        if (f)
        begin
            if (pl_elapsed != 16'hFFFF)
                pl_elapsed = pl_elapsed + 16'd1;
            if (!pl_req_open)
            begin
                if (pl_period == 16'd0 || pl_elapsed >= pl_period)
                begin
                    pl_elapsed  = 16'd0;
                    pl_req_open = 1'b1;
                    parser_restart();
                    r.event_res = EV_SENT;
                end
            end
            else if (pl_elapsed > pl_timeout)
            begin
                pl_req_open = 1'b0;
                parser_restart();
                r.event_res = EV_TIMEOUT;
            end
        end
        else if (pl_phase == PH_TYPE)
        begin
            pl_rec_type = b;
            pl_byte_pos = 9'd1;
            pl_phase    = PH_LEN;
        end
        else if (pl_phase == PH_LEN)
        begin
            total = {1'b0, b} + 9'd2;
            if (total > PACKET_BYTES)
            begin
                pl_req_open = 1'b0;
                parser_restart();
                r.event_res = EV_BIG;
            end
            else
            begin
                pl_rec_len  = total;
                pl_byte_pos = 9'd2;
                pl_phase    = PH_BODY;
                if (pl_byte_pos >= pl_rec_len)
                    close_record(r);
            end
        end
        else
        begin
            body_at = pl_byte_pos - 9'd2;
            if (pl_byte_pos >= 9'd2 && body_at < 9'(BODY_KEEP))
                pl_body[body_at[BODY_IDX_W-1:0]] = b;
            pl_byte_pos = pl_byte_pos + 9'd1;
            if (pl_byte_pos >= pl_rec_len)
                close_record(r);
        end
        r.awaiting_reply = pl_req_open;
        return r;
    endfunction

    task automatic send_word(input logic f, input logic [7:0] b);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            rx_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.func    = f;
        rx_if.rx_byte = b;
        do @(posedge clk); while (rx_if.ready !== 1'b1);
        pending_events.push_back(poll_parse_step(f, b));
        words_sent++;
        @(negedge clk);
        rx_if.valid = 1'b0;
    endtask

    task automatic send_tick();
        send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_tick();
    endtask

    // type, length, then whatever frame_body holds
    task automatic send_record(input logic [7:0] ty, input logic [7:0] len);
        int i;
        send_word(1'b0, ty);
        send_word(1'b0, len);
        for (i = 0; i < frame_body.size(); i++)
            send_word(1'b0, frame_body[i]);
    endtask

    task automatic fill_random_body(input int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        wait_drained();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        if (idx == REG_REQUEST_PERIOD)
            pl_period = val;
        else
            pl_timeout = val;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] period, input logic [15:0] tmo);
        write_reg(REG_REQUEST_PERIOD, period);
        write_reg(REG_TIMEOUT, tmo);
    endtask

    // hold res.ready low every so often to stall the result side
    initial
    begin
        int stall;
        res_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = out_idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready = 1'b1;
            do @(posedge clk); while (!(res_if.valid === 1'b1 && rst_n === 1'b1));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        step_res_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (pending_events.size() == 0)
            begin
                stray_count++;
                if (mismatch_count + stray_count <= 10)
                    $display("unexpected result word: ev=%0d", res_if.event_res);
            end
            else
            begin
                want = pending_events.pop_front();
                if (res_if.event_res !== want.event_res || res_if.pos_x !== want.pos_x
                    || res_if.pos_y !== want.pos_y || res_if.pos_z !== want.pos_z
                    || res_if.quality !== want.quality
                    || res_if.awaiting_reply !== want.awaiting_reply)
                begin
                    mismatch_count++;
                    if (mismatch_count + stray_count <= 10)
                        $display({"mismatch: expected ev=%0d x=%0d y=%0d z=%0d q=%0d ",
                                  "open=%0d, got ev=%0d x=%0d y=%0d z=%0d q=%0d open=%0d"},
                            want.event_res, want.pos_x, want.pos_y, want.pos_z,
                            want.quality, want.awaiting_reply,
                            res_if.event_res, res_if.pos_x, res_if.pos_y, res_if.pos_z,
                            res_if.quality, res_if.awaiting_reply);
                end
            end
        end
    end

    task automatic test_default_period();
        // reset period 100, reset timeout 200
        send_ticks(100);
        send_ticks(201);
    endtask

    task automatic test_poll_edges();
        set_timing(16'd0, 16'd1);
        send_ticks(4);
        // timeout drops a half-received record
        frame_body.delete();
        send_record(TY_POSITION, 8'h0D);
        send_ticks(2);
        // request issue drops a half-received record
        send_record(TY_POSITION, 8'h0D);
        send_tick();
    endtask

    task automatic test_status_records();
        set_timing(16'd0, 16'd65535);
        frame_body = '{8'h00};
        send_record(TY_STATUS, 8'h01);
        frame_body = '{8'h00, 8'h7F};
        send_record(TY_STATUS, 8'h02);
        frame_body = '{8'hFF};
        send_record(TY_STATUS, 8'h01);
        send_tick();
        frame_body.delete();
        send_record(TY_STATUS, 8'h00);
    endtask

    task automatic test_position_record();
        frame_body = '{8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00,
                       8'hFF, 8'hFF, 8'h12, 8'h34, 8'hFF};
        send_record(TY_POSITION, 8'h0D);
        frame_body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h55, 8'hFF};
        send_record(TY_POSITION, 8'h10);
        fill_random_body(12);
        send_record(TY_POSITION, 8'h0C);
    endtask

    task automatic test_list_records();
        frame_body = '{8'hAA};
        send_record(TY_DISTANCE, 8'h01);
        send_tick();
        fill_random_body(3);
        send_record(TY_ANCHOR, 8'h03);
        // no request open, parsed all the same
        frame_body = '{8'h00};
        send_record(TY_DISTANCE, 8'h01);
        send_record(8'hFF, 8'h01);
        send_record(8'h00, 8'h01);
    endtask

    task automatic test_length_limits();
        send_tick();
        frame_body.delete();
        send_record(TY_POSITION, 8'h3F);
        fill_random_body(62);
        send_record(8'h00, 8'h3E);
        send_tick();
        frame_body.delete();
        send_record(TY_STATUS, 8'hFF);
        fill_random_body(62);
        send_record(TY_POSITION, 8'h3E);
    endtask

    task automatic test_timeout_extremes();
        logic save_in;
        logic save_out;
        save_in     = in_idle_on;
        save_out    = out_idle_on;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        set_timing(16'd0, 16'd65535);
        frame_body = '{8'h01};
        send_record(TY_ANCHOR, 8'h01);
        send_tick();
        // hold the request open under the largest timeout
        send_ticks(40);
        write_reg(REG_TIMEOUT, 16'd1);
        send_tick();
        in_idle_on  = save_in;
        out_idle_on = save_out;
    endtask

    task automatic test_random_traffic();
        int phase;
        int start_count;
        int pick;
        int k;
        logic [7:0] ty;
        logic [7:0] len;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_timing(16'd0, 16'd1);
                1: set_timing(16'd1, 16'd3);
                2: set_timing(16'd0, 16'd65535);
                3: set_timing(16'd65535, 16'd65535);
                4: set_timing(16'd5, 16'd40);
                5: set_timing(16'($urandom_range(0, 20)), 16'($urandom_range(1, 30)));
                6: set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)));
                default: set_timing(16'd2, 16'd10);
            endcase
            in_idle_on  = 1'($urandom_range(0, 1));
            out_idle_on = 1'($urandom_range(0, 1));
            start_count = words_sent;
            while (words_sent - start_count < 135)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    send_ticks($urandom_range(1, 3));
                else if (pick < 75)
                begin
                    k = $urandom_range(0, 4);
                    case (k)
                        0:
                        begin
                            ty  = TY_STATUS;
                            len = 8'($urandom_range(1, 3));
                        end
                        1:
                        begin
                            ty  = TY_POSITION;
                            len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(14, 62))
                                                               : 8'd13;
                        end
                        2:
                        begin
                            ty  = TY_DISTANCE;
                            len = 8'($urandom_range(1, 8));
                        end
                        3:
                        begin
                            ty  = TY_ANCHOR;
                            len = 8'($urandom_range(1, 8));
                        end
                        default:
                        begin
                            ty  = 8'($urandom_range(0, 255));
                            len = 8'($urandom_range(0, 10));
                        end
                    endcase
                    fill_random_body(len);
                    if (ty == TY_STATUS && $urandom_range(0, 1) == 0)
                        frame_body[0] = 8'h00;
                    send_record(ty, len);
                end
                else if (pick < 85)
                begin
                    ty = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        frame_body.delete();
                        send_record(ty, 8'($urandom_range(63, 255)));
                    end
                    else
                    begin
                        len = 8'($urandom_range(2, 20));
                        fill_random_body($urandom_range(0, len - 1));
                        send_record(ty, len);
                        send_tick();
                    end
                end
                else
                    send_word(1'b0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 15) == 0)
                    in_idle_on = ~in_idle_on;
                if ($urandom_range(0, 15) == 0)
                    out_idle_on = ~out_idle_on;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.func     = 1'b0;
        rx_if.rx_byte  = 8'd0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_REQUEST_PERIOD;
        cfg_if.data    = 16'd0;
        in_idle_on     = 1'b1;
        out_idle_on    = 1'b1;
        words_sent     = 0;
        mismatch_count = 0;
        stray_count    = 0;
        poller_reset();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_period();
        test_poll_edges();
        test_status_records();
        test_position_record();
        test_list_records();
        test_length_limits();
        test_timeout_extremes();
        test_random_traffic();

        wait_drained();
        if (mismatch_count == 0 && stray_count == 0 && pending_events.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
